### hw/rtl/mexp_pkg.sv
`timescale 1ns / 1ps

package mexp_pkg;

  localparam int WORD_BITS = 32;
  localparam int CNT_BITS  = $clog2(WORD_BITS + 1);
  localparam int IDX_BITS  = 2;

  // configuration register indexes
  localparam logic [IDX_BITS-1:0] REG_EXPONENT = IDX_BITS'(0);
  localparam logic [IDX_BITS-1:0] REG_MODULUS  = IDX_BITS'(1);

  typedef logic [WORD_BITS-1:0] word_t;

endpackage

### hw/rtl/modular_exponentiation.sv
`timescale 1ns / 1ps
// Operation: the base is first reduced mod m, then one modular multiply is done
//   per set exponent bit and one square per bit below the top set bit, all on
//   one bit-serial multiplier (one multiplier bit per cycle).
// Transactions: one at a time; in_stall_o holds off a new base until idle.
// Reset: asynchronous, active low; exponent and modulus return to 1, no result pending.
module modular_exponentiation (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_valid_i,
  output logic                      cfg_ready_o,
  input  logic [mexp_pkg::IDX_BITS-1:0] cfg_index_i,
  input  mexp_pkg::word_t           cfg_data_i,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  mexp_pkg::word_t           base_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output mexp_pkg::word_t           power_o
);
  import mexp_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_STEP,
    ST_MUL,
    ST_SQR,
    ST_DONE
  } state_e;

  state_e state_q;
  word_t  exponent_q;
  word_t  modulus_q;
  word_t  exp_q;
  word_t  res_q;
  word_t  pow_q;
  word_t  op_a_q;
  word_t  op_b_q;
  logic   start_q;
  logic   out_valid_q;
  word_t  power_q;

  logic   unit_done;
  word_t  unit_result;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exponent_q <= word_t'(1);
      modulus_q  <= word_t'(1);
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_EXPONENT: exponent_q <= cfg_data_i;
        REG_MODULUS:  modulus_q  <= (cfg_data_i == '0) ? word_t'(1) : cfg_data_i;
        default: ;
      endcase
    end
  end

  mexp_mulmod u_mulmod (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (start_q),
    .mcand_i   (op_a_q),
    .mplier_i  (op_b_q),
    .modulus_i (modulus_q),
    .done_o    (unit_done),
    .result_o  (unit_result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      start_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (out_valid_q && !out_stall_i && state_q != ST_DONE) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          start_q <= in_valid_i;
          if (in_valid_i) begin
            // base mod m computed as 1 * base mod m
            op_a_q  <= word_t'(1);
            op_b_q  <= base_i;
            exp_q   <= exponent_q;
            res_q   <= word_t'(1);
            state_q <= ST_REDUCE;
          end
        end
        ST_REDUCE: begin
          start_q <= 1'b0;
          if (unit_done) begin
            pow_q   <= unit_result;
            state_q <= (exp_q == '0) ? ST_DONE : ST_STEP;
          end
        end
        ST_STEP: begin
          start_q <= 1'b1;
          if (exp_q[0]) begin
            op_a_q  <= res_q;
            op_b_q  <= pow_q;
            state_q <= ST_MUL;
          end else begin
            op_a_q  <= pow_q;
            op_b_q  <= pow_q;
            state_q <= ST_SQR;
          end
        end
        ST_MUL: begin
          start_q <= unit_done && (exp_q[WORD_BITS-1:1] != '0);
          if (unit_done) begin
            res_q <= unit_result;
            // no square needed past the top set bit
            if (exp_q[WORD_BITS-1:1] == '0) begin
              state_q <= ST_DONE;
            end else begin
              op_a_q  <= pow_q;
              op_b_q  <= pow_q;
              state_q <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          start_q <= 1'b0;
          if (unit_done) begin
            pow_q   <= unit_result;
            exp_q   <= {1'b0, exp_q[WORD_BITS-1:1]};
            state_q <= ST_STEP;
          end
        end
        ST_DONE: begin
          start_q <= 1'b0;
          if (!out_valid_q || !out_stall_i) begin
            power_q     <= res_q;
            out_valid_q <= 1'b1;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          start_q <= 1'b0;
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign power_o     = power_q;

endmodule

### hw/rtl/mexp_mulmod.sv
`timescale 1ns / 1ps

// Bit-serial modular multiplier: one multiplier bit per cycle, MSB first.
// acc <- (2*acc + bit*a) mod m, valid for acc < m and a <= max(m, 1).
module mexp_mulmod (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  mexp_pkg::word_t mcand_i,
  input  mexp_pkg::word_t mplier_i,
  input  mexp_pkg::word_t modulus_i,
  output logic           done_o,
  output mexp_pkg::word_t result_o
);
  import mexp_pkg::*;

  localparam int XW = WORD_BITS + 2;

  word_t                mcand_q;
  word_t                mplier_q, mplier_d;
  word_t                acc_q, acc_d;
  logic  [CNT_BITS-1:0] cnt_q, cnt_d;
  logic                 busy_q, busy_d;
  logic                 done_q, done_d;

  logic [XW-1:0] sum;
  logic [XW-1:0] mod1;
  logic [XW-1:0] mod2;
  logic [XW-1:0] red;

  // 2*acc + a < 3m, so at most two moduli come off; both compares run in parallel
  always_comb begin
    sum  = {1'b0, acc_q, 1'b0} + (mplier_q[WORD_BITS-1] ? {2'b00, mcand_q} : '0);
    mod1 = {2'b00, modulus_i};
    mod2 = {1'b0, modulus_i, 1'b0};
    if (sum >= mod2) begin
      red = sum - mod2;
    end else if (sum >= mod1) begin
      red = sum - mod1;
    end else begin
      red = sum;
    end
  end

  always_comb begin
    acc_d    = acc_q;
    mplier_d = mplier_q;
    cnt_d    = cnt_q;
    busy_d   = busy_q;
    done_d   = 1'b0;
    if (start_i) begin
      acc_d    = '0;
      mplier_d = mplier_i;
      cnt_d    = CNT_BITS'(WORD_BITS);
      busy_d   = 1'b1;
    end else if (busy_q) begin
      acc_d    = red[WORD_BITS-1:0];
      mplier_d = {mplier_q[WORD_BITS-2:0], 1'b0};
      cnt_d    = cnt_q - CNT_BITS'(1);
      if (cnt_q == CNT_BITS'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q    <= acc_d;
    mplier_q <= mplier_d;
    if (start_i) begin
      mcand_q <= mcand_i;
    end
  end

  assign done_o   = done_q;
  assign result_o = acc_q;

endmodule

### tb/mexp_checker.sv
`timescale 1ns / 1ps

// Watches the config, base and power channels, predicts each power from the
// register values in force when the base was taken, and compares in order.
module mexp_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [mexp_pkg::IDX_BITS-1:0] cfg_index_i,
  input  mexp_pkg::word_t               cfg_data_i,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  mexp_pkg::word_t               base_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  mexp_pkg::word_t               power_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import mexp_pkg::*;

  typedef struct packed {
    word_t base;
    word_t power;
  } power_entry_t;

  power_entry_t expected_powers[$];
  word_t        exponent_q;
  word_t        modulus_q;
  int           fails = 0;

  // Right-to-left square-and-multiply; products fit exactly in 64 bits.
  function automatic word_t raise_power(word_t base, word_t expo, word_t modn);
    logic [63:0] m;
    logic [63:0] acc;
    logic [63:0] sq;
    m   = 64'(modn);
    acc = 64'd1;
    sq  = 64'(base) % m;
    for (int k = 0; k < WORD_BITS; k++) begin
      if (expo[k]) acc = (acc * sq) % m;
      sq = (sq * sq) % m;
    end
    return word_t'(acc);
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    power_entry_t entry;
    if (!rst_ni) begin
      exponent_q = word_t'(1);
      modulus_q  = word_t'(1);
      expected_powers.delete();
      pending_o    <= 0;
      fail_count_o <= 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_EXPONENT: exponent_q = cfg_data_i;
          REG_MODULUS:  modulus_q  = (cfg_data_i == '0) ? word_t'(1) : cfg_data_i;
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) begin
        entry.base  = base_i;
        entry.power = raise_power(base_i, exponent_q, modulus_q);
        expected_powers.push_back(entry);
      end
      if (out_valid_i && !out_stall_i) begin
        if (expected_powers.size() == 0) begin
          fails++;
          if (fails <= 10) $display("%t: power %h with no base outstanding", $time, power_i);
        end else begin
          entry = expected_powers.pop_front();
          if (power_i !== entry.power) begin
            fails++;
            if (fails <= 10)
              $display("%t: power mismatch, base %h: expected %h, got %h",
                       $time, entry.base, entry.power, power_i);
          end
        end
      end
      pending_o    <= expected_powers.size();
      fail_count_o <= fails;
    end
  end

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import mexp_pkg::*;

  // not a register; writes here must be ignored
  localparam logic [IDX_BITS-1:0] REG_SPARE = IDX_BITS'(3);
  localparam int RANDOM_BASES = 247;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                cfg_valid   = 1'b0;
  logic [IDX_BITS-1:0] cfg_index   = '0;
  word_t               cfg_data    = '0;
  logic                in_valid    = 1'b0;
  word_t               base        = '0;
  logic                out_stall   = 1'b0;
  logic                cfg_ready;
  logic                in_stall;
  logic                out_valid;
  word_t               power;
  int                  fail_count;
  int                  pending;

  int    idle_pct  = 16;
  int    stall_pct = 16;
  int    bases_sent  = 0;
  int    reg_writes  = 0;
  word_t modulus_now = word_t'(1);

  always #6 clk_i = ~clk_i;

  modular_exponentiation u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .base_i      (base),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .power_o     (power)
  );

  mexp_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid),
    .cfg_ready_i  (cfg_ready),
    .cfg_index_i  (cfg_index),
    .cfg_data_i   (cfg_data),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .base_i       (base),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .power_i      (power),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always @(posedge clk_i) out_stall <= ($urandom_range(99, 0) < stall_pct);

  // valid stays high on return so back-to-back bases need no re-raise
  task automatic send_base(word_t b);
    while ($urandom_range(99, 0) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    base     <= b;
    do @(posedge clk_i); while (in_stall);
    bases_sent++;
  endtask

  // stop sending and wait until every power is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
  endtask

  task automatic write_reg(logic [IDX_BITS-1:0] idx, word_t data, bit last);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    if (idx == REG_MODULUS) modulus_now = (data == '0) ? word_t'(1) : data;
    reg_writes++;
    if (last) cfg_valid <= 1'b0;
  endtask

  task automatic set_regs(word_t expo, word_t modn);
    drain();
    if ($urandom_range(1, 0)) begin
      write_reg(REG_EXPONENT, expo, 1'b0);
      write_reg(REG_MODULUS, modn, 1'b1);
    end else begin
      write_reg(REG_MODULUS, modn, 1'b0);
      write_reg(REG_EXPONENT, expo, 1'b1);
    end
  endtask

  function automatic word_t pick_exponent();
    case ($urandom_range(9, 0))
      0:       return '0;
      1:       return '1;
      default: return word_t'($urandom()) >> $urandom_range(31, 0);
    endcase
  endfunction

  function automatic word_t pick_modulus();
    case ($urandom_range(7, 0))
      0:       return word_t'($urandom_range(300, 1));
      1:       return word_t'(1) << $urandom_range(31, 0);
      2:       return '1;
      3:       return '0;
      default: return word_t'($urandom());
    endcase
  endfunction

  function automatic word_t pick_base();
    case ($urandom_range(7, 0))
      0:       return '0;
      1:       return '1;
      2:       return modulus_now + word_t'($urandom_range(2, 0)) - word_t'(1);
      3:       return word_t'($urandom_range(255, 0));
      default: return word_t'($urandom());
    endcase
  endfunction

  initial begin
    int phase;
    int phase_len;
    int left;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // registers still at reset: exponent 1, modulus 1
    send_base('0);
    send_base('1);

    // zero exponent yields 1 even with modulus 1
    set_regs('0, word_t'(1));
    send_base(word_t'(5));
    send_base('1);

    set_regs('1, '1);
    send_base('0);
    send_base(word_t'(1));
    send_base(32'hFFFF_FFFE);
    send_base('1);
    send_base(32'h8000_0000);
    send_base(word_t'($urandom()));

    // modulus written as zero is held at 1
    set_regs(32'h1234_5678, '0);
    send_base(word_t'(7));
    send_base('1);
    drain();
    write_reg(REG_SPARE, '1, 1'b1);
    send_base(word_t'(9));

    set_regs(word_t'(2), 32'h0001_0001);
    send_base(32'h0001_0001);
    send_base(32'h0001_0002);
    send_base('1);
    send_base(32'hAAAA_AAAA);
    send_base(32'h5555_5555);

    set_regs(word_t'(65537), 32'hFFFF_FFFB);
    send_base(word_t'(2));
    send_base(word_t'(3));
    send_base(32'hDEAD_BEEF);

    set_regs(32'h8000_0000, 32'h8000_0000);
    send_base(word_t'(2));
    send_base(word_t'(3));

    left  = RANDOM_BASES;
    phase = 0;
    while (left > 0) begin
      set_regs(pick_exponent(), pick_modulus());
      // one phase with no gaps on either side
      idle_pct  = (phase == 3) ? 0 : 16;
      stall_pct = (phase == 3) ? 0 : 16;
      phase_len = (phase == 3) ? 40 : $urandom_range(30, 8);
      for (int k = 0; k < phase_len && left > 0; k++) begin
        send_base(pick_base());
        left--;
      end
      phase++;
    end
    idle_pct  = 16;
    stall_pct = 16;

    drain();
    repeat (2500) @(posedge clk_i);

    $display("Covered %0d bases across %0d register writes, incl. zero and all-ones",
             bases_sent, reg_writes);
    $display("exponent/modulus, modulus written as zero, spare index, bases at and past n.");
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #40ms;
    $display("Timeout with %0d powers outstanding", pending);
    $display("Regression FAIL");
    $finish;
  end

endmodule
